FILE: rtl/core/swe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package swe_pkg;

  typedef enum logic [4:0] {
    OP_LIT     = 5'd0,
    OP_DOT     = 5'd1,
    OP_EMIT    = 5'd2,
    OP_DROP    = 5'd3,
    OP_NIP     = 5'd4,
    OP_DUP     = 5'd5,
    OP_SWAP    = 5'd6,
    OP_OVER    = 5'd7,
    OP_ROT     = 5'd8,
    OP_MROT    = 5'd9,
    OP_PICK    = 5'd10,
    OP_ROLL    = 5'd11,
    OP_QDUP    = 5'd12,
    OP_TRUE    = 5'd13,
    OP_FALSE   = 5'd14,
    OP_LESS    = 5'd15,
    OP_GREATER = 5'd16,
    OP_EQ      = 5'd17,
    OP_NE      = 5'd18,
    OP_ZEQ     = 5'd19,
    OP_ZNE     = 5'd20,
    OP_NEGATE  = 5'd21,
    OP_PLUS    = 5'd22,
    OP_MINUS   = 5'd23,
    OP_TIMES   = 5'd24,
    OP_DIV     = 5'd25,
    OP_MOD     = 5'd26,
    OP_DIVMOD  = 5'd27,
    OP_ABS     = 5'd28,
    OP_MIN     = 5'd29,
    OP_MAX     = 5'd30,
    OP_NOP     = 5'd31
  } op_e;

  typedef enum logic [2:0] {
    STS_OK    = 3'd0,
    STS_UNDER = 3'd1,
    STS_RANGE = 3'd2,
    STS_FULL  = 3'd3,
    STS_DIVZ  = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_T,
    ST_RD_N,
    ST_EXEC,
    ST_ARITH,
    ST_PICK_RD,
    ST_PICK_WR,
    ST_SH_HOLD,
    ST_SH_CAP,
    ST_SH_RD,
    ST_SH_WR,
    ST_WR_A,
    ST_WR_B,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    ACT_DONE,
    ACT_WRITE,
    ACT_PICK,
    ACT_SHIFT,
    ACT_ARITH
  } act_e;

  typedef struct packed {
    logic start;
    logic is_div;
  } ar_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ar_stat_t;

  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned IN_USER_W  = 5;
  localparam int unsigned OUT_DATA_W = 48;
  localparam int unsigned OUT_USER_W = 2;
  localparam int unsigned OUT_VAL_W  = 32;
  localparam int unsigned DEPTH_W    = 6;

endpackage

`default_nettype wire

FILE: rtl/core/stack_word_executor_top.sv
// Channel   Dir  Content
// s_axis    in   tuser: operation; tdata: literal
// m_axis    out  tuser: has_output, output_is_char; tdata: status, output_value, stack_depth
//
// Each word reads top and second from the stack RAM; all but the shifting words then
// write 0 to 2 cells. Times, divide, modulo and divmod also run in the bit-serial arith
// unit. Rot, minus-rot and roll move cells through the RAM's one read and one write
// port, with a read state and a write state per cell moved. Pick adds an indexed read.
// Reset empties the stack at once; cell contents are not cleared.
// A finished result waits in the output register; the next word is taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module stack_word_executor_top #(
  parameter int unsigned STACK_DEPTH = 32,
  parameter int unsigned CELL_WIDTH  = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [swe_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // literal[31:0]
  input  logic [swe_pkg::IN_USER_W-1:0]       s_axis_tuser,  // operation[4:0]
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [swe_pkg::OUT_DATA_W-1:0]      m_axis_tdata,  // status, output_value, stack_depth
  output logic [swe_pkg::OUT_USER_W-1:0]      m_axis_tuser   // has_output, output_is_char
);

  localparam int unsigned W  = CELL_WIDTH;
  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned XW = ((W > CW) ? W : CW) + 1;
  localparam int unsigned VW = swe_pkg::OUT_VAL_W;
  localparam int unsigned DW = swe_pkg::DEPTH_W;

  swe_pkg::state_e  state_q, state_d;
  swe_pkg::op_e     op_q, op_d;
  swe_pkg::status_e sts_q, sts_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [W-1:0]     lit_q, lit_d, t_q, t_d, n_q, n_d, held_q, held_d;
  logic [W-1:0]     wa_data_q, wa_data_d, wb_data_q, wb_data_d;
  logic [AW-1:0]    wa_addr_q, wa_addr_d, wb_addr_q, wb_addr_d;
  logic [AW-1:0]    ptr_q, ptr_d, end_q, end_d;
  logic             wb_en_q, wb_en_d, up_q, up_d;
  logic             has_q, has_d, ischar_q, ischar_d;
  logic [VW-1:0]    val_q, val_d;
  logic             m_valid_q, m_valid_d;
  logic [swe_pkg::OUT_DATA_W-1:0] m_data_q, m_data_d;
  logic [swe_pkg::OUT_USER_W-1:0] m_user_q, m_user_d;

  // stack RAM port
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [W-1:0]  mem_wdata, mem_rdata;

  swe_stack_mem #(
    .DEPTH (STACK_DEPTH),
    .W     (W),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  swe_pkg::ar_ctrl_t ar_ctrl;
  swe_pkg::ar_stat_t ar_stat;
  logic [W-1:0]      ar_prod, ar_quo, ar_rem;

  swe_arith #(
    .W (W)
  ) u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ar_ctrl),
    .a_i    (t_q),
    .b_i    (n_q),
    .stat_o (ar_stat),
    .prod_o (ar_prod),
    .quo_o  (ar_quo),
    .rem_o  (ar_rem)
  );

  // address and operand helpers
  logic [CW-1:0] dp1, dm1, dm2, dm3;
  logic [XW-1:0] t_x, d_x, pick_x;
  logic          full, idx_bad, lt_nt, lt_tn, s_fire, m_free;
  logic [W+31:0] lit_ext;
  logic [W+31:0] dot_ext;
  logic [AW-1:0] sh_src;
  logic [W-1:0]  neg_t, q_sgn, r_sgn, quo_neg, rem_neg;
  logic [CW+DW-1:0] depth_ext;

  assign dp1     = cnt_q + CW'(1);
  assign dm1     = cnt_q - CW'(1);
  assign dm2     = cnt_q - CW'(2);
  assign dm3     = cnt_q - CW'(3);
  assign t_x     = {{(XW-W){1'b0}}, t_q};
  assign d_x     = {{(XW-CW){1'b0}}, cnt_q};
  assign pick_x  = d_x - XW'(2) - t_x;
  assign full    = (cnt_q == CW'(STACK_DEPTH));
  assign idx_bad = t_q[W-1] || (t_x >= (d_x - XW'(1)));
  assign lt_nt   = $signed(n_q) < $signed(t_q);
  assign lt_tn   = $signed(t_q) < $signed(n_q);
  assign lit_ext = {{W{s_axis_tdata[31]}}, s_axis_tdata[31:0]};
  assign dot_ext = {{32{t_q[W-1]}}, t_q};
  assign sh_src  = up_q ? (ptr_q + AW'(1)) : (ptr_q - AW'(1));
  assign neg_t   = ~t_q + W'(1);
  assign quo_neg = ~ar_quo + W'(1);
  assign rem_neg = ~ar_rem + W'(1);
  assign q_sgn   = (t_q[W-1] ^ n_q[W-1]) ? quo_neg : ar_quo;
  assign r_sgn   = t_q[W-1] ? rem_neg : ar_rem;
  assign s_fire  = s_axis_tvalid && s_axis_tready;
  assign m_free  = !m_valid_q || m_axis_tready;
  assign depth_ext = {{DW{1'b0}}, cnt_q};

  // word decode, evaluated in ST_EXEC
  swe_pkg::status_e ex_sts;
  swe_pkg::act_e    ex_act;
  logic [CW-1:0]    ex_cnt;
  logic [AW-1:0]    ex_wa_addr, ex_wb_addr, ex_ptr, ex_end;
  logic [W-1:0]     ex_wa_data, ex_wb_data;
  logic             ex_wb_en, ex_up, ex_div, ex_has, ex_ischar;
  logic [VW-1:0]    ex_val;

  always_comb begin
    ex_sts     = swe_pkg::STS_OK;
    ex_act     = swe_pkg::ACT_DONE;
    ex_cnt     = cnt_q;
    ex_wa_addr = cnt_q[AW-1:0];
    ex_wa_data = t_q;
    ex_wb_en   = 1'b0;
    ex_wb_addr = dm2[AW-1:0];
    ex_wb_data = t_q;
    ex_ptr     = dm3[AW-1:0];
    ex_end     = dm1[AW-1:0];
    ex_up      = 1'b1;
    ex_div     = 1'b0;
    ex_has     = 1'b0;
    ex_ischar  = 1'b0;
    ex_val     = '0;
    case (op_q)
      swe_pkg::OP_LIT, swe_pkg::OP_TRUE, swe_pkg::OP_FALSE: begin
        if (full) begin
          ex_sts = swe_pkg::STS_FULL;
        end else begin
          ex_act     = swe_pkg::ACT_WRITE;
          ex_cnt     = dp1;
          ex_wa_data = (op_q == swe_pkg::OP_LIT) ? lit_q :
                       {W{op_q == swe_pkg::OP_TRUE}};
        end
      end
      swe_pkg::OP_DOT, swe_pkg::OP_EMIT, swe_pkg::OP_DROP: begin
        if (cnt_q == '0) begin
          ex_sts = swe_pkg::STS_UNDER;
        end else begin
          ex_cnt = dm1;
          if (op_q == swe_pkg::OP_DOT) begin
            ex_has = 1'b1;
            ex_val = dot_ext[VW-1:0];
          end else if (op_q == swe_pkg::OP_EMIT) begin
            ex_has    = 1'b1;
            ex_ischar = 1'b1;
            ex_val    = {{(VW-8){1'b0}}, t_q[7:0]};
          end
        end
      end
      swe_pkg::OP_NIP: begin
        if (cnt_q < CW'(2)) begin
          ex_sts = swe_pkg::STS_RANGE;
        end else begin
          ex_act     = swe_pkg::ACT_WRITE;
          ex_cnt     = dm1;
          ex_wa_addr = dm2[AW-1:0];
        end
      end
      swe_pkg::OP_DUP, swe_pkg::OP_QDUP: begin
        if (cnt_q == '0) begin
          ex_sts = swe_pkg::STS_UNDER;
        end else if (full) begin
          ex_sts = swe_pkg::STS_FULL;
        end else if (op_q == swe_pkg::OP_DUP || t_q != '0) begin
          ex_act = swe_pkg::ACT_WRITE;
          ex_cnt = dp1;
        end
      end
      swe_pkg::OP_SWAP: begin
        if (cnt_q < CW'(2)) begin
          ex_sts = swe_pkg::STS_UNDER;
        end else begin
          ex_act     = swe_pkg::ACT_WRITE;
          ex_wa_addr = dm1[AW-1:0];
          ex_wa_data = n_q;
          ex_wb_en   = 1'b1;
        end
      end
      swe_pkg::OP_OVER: begin
        if (cnt_q < CW'(2)) begin
          ex_sts = swe_pkg::STS_RANGE;
        end else if (full) begin
          ex_sts = swe_pkg::STS_FULL;
        end else begin
          ex_act     = swe_pkg::ACT_WRITE;
          ex_cnt     = dp1;
          ex_wa_data = n_q;
        end
      end
      swe_pkg::OP_ROT, swe_pkg::OP_MROT: begin
        if (cnt_q == '0) begin
          ex_sts = swe_pkg::STS_UNDER;
        end else if (cnt_q == CW'(2)) begin
          ex_act     = swe_pkg::ACT_WRITE;
          ex_wa_addr = dm1[AW-1:0];
          ex_wa_data = n_q;
          ex_wb_en   = 1'b1;
        end else if (cnt_q > CW'(2)) begin
          ex_act = swe_pkg::ACT_SHIFT;
          if (op_q == swe_pkg::OP_ROT) begin
            ex_up  = 1'b0;
            ex_ptr = dm1[AW-1:0];
            ex_end = dm3[AW-1:0];
          end
        end
      end
      swe_pkg::OP_PICK: begin
        if (cnt_q == '0) begin
          ex_sts = swe_pkg::STS_UNDER;
        end else if (full) begin
          ex_sts = swe_pkg::STS_FULL;
        end else if (idx_bad) begin
          ex_sts = swe_pkg::STS_RANGE;
        end else begin
          ex_act = swe_pkg::ACT_PICK;
          ex_cnt = dp1;
          ex_ptr = pick_x[AW-1:0];
        end
      end
      swe_pkg::OP_ROLL: begin
        if (cnt_q == '0) begin
          ex_sts = swe_pkg::STS_UNDER;
        end else begin
          ex_cnt = dm1;
          if (t_q != '0) begin
            if (idx_bad) begin
              ex_sts = swe_pkg::STS_RANGE;
            end else begin
              ex_act = swe_pkg::ACT_SHIFT;
              ex_ptr = pick_x[AW-1:0];
              ex_end = dm2[AW-1:0];
            end
          end
        end
      end
      swe_pkg::OP_ZEQ, swe_pkg::OP_ZNE, swe_pkg::OP_NEGATE, swe_pkg::OP_ABS: begin
        if (cnt_q == '0) begin
          ex_sts = swe_pkg::STS_UNDER;
        end else begin
          ex_act     = swe_pkg::ACT_WRITE;
          ex_wa_addr = dm1[AW-1:0];
          if (op_q == swe_pkg::OP_ZEQ || op_q == swe_pkg::OP_ZNE) begin
            ex_wa_data = {W{(t_q == '0) == (op_q == swe_pkg::OP_ZEQ)}};
          end else if (op_q == swe_pkg::OP_NEGATE || t_q[W-1]) begin
            ex_wa_data = neg_t;
          end
        end
      end
      swe_pkg::OP_NOP: begin
        ex_sts = swe_pkg::STS_OK;
      end
      default: begin
        if (cnt_q < CW'(2)) begin
          ex_sts = swe_pkg::STS_UNDER;
        end else if ((op_q == swe_pkg::OP_DIV || op_q == swe_pkg::OP_MOD ||
                      op_q == swe_pkg::OP_DIVMOD) && n_q == '0) begin
          ex_sts = swe_pkg::STS_DIVZ;
        end else begin
          ex_act     = swe_pkg::ACT_WRITE;
          ex_cnt     = dm1;
          ex_wa_addr = dm2[AW-1:0];
          ex_wb_addr = dm1[AW-1:0];
          case (op_q)
            swe_pkg::OP_LESS:    ex_wa_data = {W{lt_nt}};
            swe_pkg::OP_GREATER: ex_wa_data = {W{lt_tn}};
            swe_pkg::OP_EQ:      ex_wa_data = {W{n_q == t_q}};
            swe_pkg::OP_NE:      ex_wa_data = {W{n_q != t_q}};
            swe_pkg::OP_PLUS:    ex_wa_data = t_q + n_q;
            swe_pkg::OP_MINUS:   ex_wa_data = t_q - n_q;
            swe_pkg::OP_MIN:     ex_wa_data = lt_tn ? t_q : n_q;
            swe_pkg::OP_MAX:     ex_wa_data = lt_nt ? t_q : n_q;
            swe_pkg::OP_TIMES: begin
              ex_act = swe_pkg::ACT_ARITH;
            end
            swe_pkg::OP_DIV, swe_pkg::OP_MOD: begin
              ex_act = swe_pkg::ACT_ARITH;
              ex_div = 1'b1;
            end
            swe_pkg::OP_DIVMOD: begin
              ex_act   = swe_pkg::ACT_ARITH;
              ex_div   = 1'b1;
              ex_cnt   = cnt_q;
              ex_wb_en = 1'b1;
            end
            default: ex_wa_data = t_q;
          endcase
        end
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      swe_pkg::ST_IDLE:    if (s_fire) state_d = swe_pkg::ST_RD_T;
      swe_pkg::ST_RD_T:    state_d = swe_pkg::ST_RD_N;
      swe_pkg::ST_RD_N:    state_d = swe_pkg::ST_EXEC;
      swe_pkg::ST_EXEC: begin
        case (ex_act)
          swe_pkg::ACT_WRITE: state_d = swe_pkg::ST_WR_A;
          swe_pkg::ACT_PICK:  state_d = swe_pkg::ST_PICK_RD;
          swe_pkg::ACT_SHIFT: state_d = swe_pkg::ST_SH_HOLD;
          swe_pkg::ACT_ARITH: state_d = swe_pkg::ST_ARITH;
          default:            state_d = swe_pkg::ST_DONE;
        endcase
      end
      swe_pkg::ST_ARITH:   if (ar_stat.done) state_d = swe_pkg::ST_WR_A;
      swe_pkg::ST_PICK_RD: state_d = swe_pkg::ST_PICK_WR;
      swe_pkg::ST_PICK_WR: state_d = swe_pkg::ST_DONE;
      swe_pkg::ST_SH_HOLD: state_d = swe_pkg::ST_SH_CAP;
      swe_pkg::ST_SH_CAP:  state_d = swe_pkg::ST_SH_RD;
      swe_pkg::ST_SH_RD:   state_d = swe_pkg::ST_SH_WR;
      swe_pkg::ST_SH_WR: begin
        state_d = (sh_src == end_q) ? swe_pkg::ST_WR_A : swe_pkg::ST_SH_RD;
      end
      swe_pkg::ST_WR_A:    state_d = wb_en_q ? swe_pkg::ST_WR_B : swe_pkg::ST_DONE;
      swe_pkg::ST_WR_B:    state_d = swe_pkg::ST_DONE;
      swe_pkg::ST_DONE:    if (m_free) state_d = swe_pkg::ST_IDLE;
      default:             state_d = swe_pkg::ST_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    op_d      = op_q;
    lit_d     = lit_q;
    t_d       = t_q;
    n_d       = n_q;
    held_d    = held_q;
    cnt_d     = cnt_q;
    sts_d     = sts_q;
    has_d     = has_q;
    ischar_d  = ischar_q;
    val_d     = val_q;
    wa_addr_d = wa_addr_q;
    wa_data_d = wa_data_q;
    wb_en_d   = wb_en_q;
    wb_addr_d = wb_addr_q;
    wb_data_d = wb_data_q;
    ptr_d     = ptr_q;
    end_d     = end_q;
    up_d      = up_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    mem_we    = 1'b0;
    mem_waddr = wa_addr_q;
    mem_wdata = wa_data_q;
    mem_raddr = dm1[AW-1:0];
    ar_ctrl.start  = 1'b0;
    ar_ctrl.is_div = ex_div;

    if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      swe_pkg::ST_IDLE: begin
        mem_raddr = dm1[AW-1:0];
        if (s_fire) begin
          op_d  = swe_pkg::op_e'(s_axis_tuser[4:0]);
          lit_d = lit_ext[W-1:0];
        end
      end
      swe_pkg::ST_RD_T: begin
        t_d       = mem_rdata;
        mem_raddr = dm2[AW-1:0];
      end
      swe_pkg::ST_RD_N: begin
        n_d = mem_rdata;
      end
      swe_pkg::ST_EXEC: begin
        sts_d     = ex_sts;
        cnt_d     = ex_cnt;
        has_d     = ex_has;
        ischar_d  = ex_ischar;
        val_d     = ex_val;
        wa_addr_d = ex_wa_addr;
        wa_data_d = ex_wa_data;
        wb_en_d   = ex_wb_en;
        wb_addr_d = ex_wb_addr;
        wb_data_d = ex_wb_data;
        ptr_d     = ex_ptr;
        end_d     = ex_end;
        up_d      = ex_up;
        ar_ctrl.start = (ex_act == swe_pkg::ACT_ARITH);
      end
      swe_pkg::ST_ARITH: begin
        if (ar_stat.done) begin
          wb_data_d = q_sgn;
          if (op_q == swe_pkg::OP_TIMES) begin
            wa_data_d = ar_prod;
          end else if (op_q == swe_pkg::OP_DIV) begin
            wa_data_d = q_sgn;
          end else begin
            wa_data_d = r_sgn;
          end
        end
      end
      swe_pkg::ST_PICK_RD: begin
        mem_raddr = ptr_q;
      end
      swe_pkg::ST_PICK_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
      end
      swe_pkg::ST_SH_HOLD: begin
        mem_raddr = ptr_q;
      end
      swe_pkg::ST_SH_CAP: begin
        held_d = mem_rdata;
      end
      swe_pkg::ST_SH_RD: begin
        mem_raddr = sh_src;
      end
      swe_pkg::ST_SH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q;
        mem_wdata = mem_rdata;
        ptr_d     = sh_src;
        wa_addr_d = sh_src;
        wa_data_d = held_q;
      end
      swe_pkg::ST_WR_A: begin
        mem_we = 1'b1;
      end
      swe_pkg::ST_WR_B: begin
        mem_we    = 1'b1;
        mem_waddr = wb_addr_q;
        mem_wdata = wb_data_q;
      end
      swe_pkg::ST_DONE: begin
        if (m_free) begin
          m_valid_d = 1'b1;
          m_data_d  = '0;
          m_data_d[2:0]          = sts_q;
          m_data_d[VW+2:3]       = val_q;
          m_data_d[VW+DW+2:VW+3] = depth_ext[DW-1:0];
          m_user_d  = {ischar_q, has_q};
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= swe_pkg::ST_IDLE;
      op_q      <= swe_pkg::OP_NOP;
      sts_q     <= swe_pkg::STS_OK;
      cnt_q     <= '0;
      lit_q     <= '0;
      t_q       <= '0;
      n_q       <= '0;
      held_q    <= '0;
      has_q     <= 1'b0;
      ischar_q  <= 1'b0;
      val_q     <= '0;
      wa_addr_q <= '0;
      wa_data_q <= '0;
      wb_en_q   <= 1'b0;
      wb_addr_q <= '0;
      wb_data_q <= '0;
      ptr_q     <= '0;
      end_q     <= '0;
      up_q      <= 1'b0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      m_user_q  <= '0;
    end else begin
      state_q   <= state_d;
      op_q      <= op_d;
      sts_q     <= sts_d;
      cnt_q     <= cnt_d;
      lit_q     <= lit_d;
      t_q       <= t_d;
      n_q       <= n_d;
      held_q    <= held_d;
      has_q     <= has_d;
      ischar_q  <= ischar_d;
      val_q     <= val_d;
      wa_addr_q <= wa_addr_d;
      wa_data_q <= wa_data_d;
      wb_en_q   <= wb_en_d;
      wb_addr_q <= wb_addr_d;
      wb_data_q <= wb_data_d;
      ptr_q     <= ptr_d;
      end_q     <= end_d;
      up_q      <= up_d;
      m_valid_q <= m_valid_d;
      m_data_q  <= m_data_d;
      m_user_q  <= m_user_d;
    end
  end

  assign s_axis_tready = (state_q == swe_pkg::ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_cnt_only_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> ($past(state_q) == swe_pkg::ST_EXEC))
    else $error("stack count changed outside execute");

  a_arith_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ar_stat.busy || ar_stat.done) |-> (state_q == swe_pkg::ST_ARITH))
    else $error("arith unit active outside arith state");

  a_print_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_user_q[0]) |-> (m_data_q[2:0] == swe_pkg::STS_OK))
    else $error("printed value with error status");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == swe_pkg::ST_IDLE) |-> !mem_we)
    else $error("stack write while idle");

endmodule

`default_nettype wire

FILE: rtl/core/swe_stack_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module swe_stack_mem #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned W     = 32,
  parameter int unsigned AW    = 5
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem_q [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/core/swe_arith.sv
`timescale 1ns / 1ps
`default_nettype none

module swe_arith #(
  parameter int unsigned W = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  swe_pkg::ar_ctrl_t  ctrl_i,
  input  logic [W-1:0]       a_i,
  input  logic [W-1:0]       b_i,
  output swe_pkg::ar_stat_t  stat_o,
  output logic [W-1:0]       prod_o,
  output logic [W-1:0]       quo_o,
  output logic [W-1:0]       rem_o
);

  localparam int unsigned CNTW = $clog2(W + 1);

  logic            busy_q, busy_d, done_q, done_d, div_q, div_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [W-1:0]    x_q, x_d, y_q, y_d;
  logic [W:0]      acc_q, acc_d, sh;
  logic [W-1:0]    mag_a, mag_b;

  assign mag_a = a_i[W-1] ? (~a_i + W'(1)) : a_i;
  assign mag_b = b_i[W-1] ? (~b_i + W'(1)) : b_i;

  // shift-add multiply, restoring divide; one bit per cycle
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    div_d  = div_q;
    cnt_d  = cnt_q;
    x_d    = x_q;
    y_d    = y_q;
    acc_d  = acc_q;
    sh     = {acc_q[W-1:0], x_q[W-1]};
    if (ctrl_i.start) begin
      busy_d = 1'b1;
      div_d  = ctrl_i.is_div;
      x_d    = ctrl_i.is_div ? mag_a : a_i;
      y_d    = ctrl_i.is_div ? mag_b : b_i;
      acc_d  = '0;
      cnt_d  = CNTW'(W);
    end else if (busy_q) begin
      if (div_q) begin
        x_d = {x_q[W-2:0], 1'b0};
        if (sh >= {1'b0, y_q}) begin
          acc_d  = sh - {1'b0, y_q};
          x_d[0] = 1'b1;
        end else begin
          acc_d = sh;
        end
      end else begin
        if (y_q[0]) begin
          acc_d = {1'b0, acc_q[W-1:0] + x_q};
        end
        x_d = {x_q[W-2:0], 1'b0};
        y_d = {1'b0, y_q[W-1:1]};
      end
      cnt_d = cnt_q - CNTW'(1);
      if (cnt_q == CNTW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      div_q  <= 1'b0;
      cnt_q  <= '0;
      x_q    <= '0;
      y_q    <= '0;
      acc_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      div_q  <= div_d;
      cnt_q  <= cnt_d;
      x_q    <= x_d;
      y_q    <= y_d;
      acc_q  <= acc_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign prod_o      = acc_q[W-1:0];
  assign quo_o       = x_q;
  assign rem_o       = acc_q[W-1:0];

endmodule

`default_nettype wire
